[hdl/mbecb_pkg.sv]
package mbecb_pkg;

  // One byte carries eight pixels, one per lane.
  localparam int LANES    = 8;
  localparam int LANE_W   = $clog2(LANES);
  localparam int OFFSET_W = 17;
  localparam int COLOUR_W = 16;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_BITMAP_WIDTH = 3'd2,
    CFG_CLIP_X       = 3'd3,
    CFG_CLIP_Y       = 3'd4,
    CFG_CLIP_WIDTH   = 3'd5,
    CFG_CLIP_HEIGHT  = 3'd6,
    CFG_COLOUR_PAIR  = 3'd7
  } cfg_reg_t;

  // Everything a lane needs that is common to the whole byte.
  typedef struct packed {
    logic [9:0]               col_base;
    logic [9:0]               bw;
    logic signed [17:0]       ox;
    logic signed [17:0]       cx;
    logic signed [17:0]       cx_end;
    logic                     y_in;
    logic [OFFSET_W-1:0]      y_term;
    logic [COLOUR_W-1:0]      fg;
    logic [COLOUR_W-1:0]      bg;
  } byte_ctx_t;

  // What one lane found for its pixel.
  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
    logic [COLOUR_W-1:0] colour;
  } lane_res_t;

  function automatic logic [COLOUR_W-1:0] to_rgb565(input logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

[hdl/mbecb_lane.sv]
module mbecb_lane #(
  parameter int LANE          = 0,
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 272,
  parameter int ROTATION      = 0
) (
  input  mbecb_pkg::byte_ctx_t ctx,
  input  logic                 pix_bit,
  output mbecb_pkg::lane_res_t res
);
  import mbecb_pkg::*;

  localparam logic [OFFSET_W-1:0] W17 = OFFSET_W'(SCREEN_WIDTH);
  localparam logic [OFFSET_W-1:0] H17 = OFFSET_W'(SCREEN_HEIGHT);
  localparam logic [1:0]          ROT = 2'(ROTATION);

  logic [9:0]          col;
  logic signed [17:0]  x;
  logic                x_in;
  logic                in_bm;
  logic [OFFSET_W-1:0] x17;
  logic [OFFSET_W-1:0] x_term;

  assign col   = ctx.col_base + 10'(LANE);
  assign in_bm = col < ctx.bw;
  assign x     = ctx.ox + $signed({8'b0, col});
  assign x_in  = (x >= ctx.cx) && (x < ctx.cx_end);
  // Screen x is reduced to 16-bit two's complement before the offset math.
  assign x17   = {x[15], x[15:0]};

  always_comb begin
    unique case (ROT)
      2'd0:    x_term = x17;
      2'd1:    x_term = OFFSET_W'(x17 * W17);
      2'd2:    x_term = W17 - OFFSET_W'(1) - x17;
      default: x_term = OFFSET_W'((H17 - OFFSET_W'(1) - x17) * W17);
    endcase
  end

  assign res.hit    = in_bm && ctx.y_in && x_in;
  assign res.offset = x_term + ctx.y_term;
  assign res.colour = pix_bit ? ctx.bg : ctx.fg;

endmodule

[hdl/mbecb_serial.sv]
module mbecb_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  mbecb_pkg::lane_res_t lanes [mbecb_pkg::LANES],
  output logic                 load_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          pixel_offset,
  output logic [15:0]          pixel_color,
  output logic                 last_of_byte
);
  import mbecb_pkg::*;

  logic [LANES-1:0]    mask;
  logic [LANES-1:0]    mask_next;
  logic [LANES-1:0]    rest;
  logic [LANES-1:0]    new_mask;
  logic [OFFSET_W-1:0] offs [LANES];
  logic [COLOUR_W-1:0] cols [LANES];
  logic [LANE_W-1:0]   sel;
  logic                fire;
  logic                load;

  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = LANE_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      new_mask[i] = lanes[i].hit;
    end
  end

  assign rest       = mask & (mask - LANES'(1));
  assign out_valid  = mask != '0;
  assign fire       = out_valid && !out_stall;
  assign load_ready = (mask == '0) || (fire && rest == '0);
  assign load       = load_valid && load_ready;

  assign pixel_offset = offs[sel];
  assign pixel_color  = cols[sel];
  assign last_of_byte = rest == '0;

  always_comb begin
    if (load) begin
      mask_next = new_mask;
    end else if (fire) begin
      mask_next = rest;
    end else begin
      mask_next = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < LANES; i++) begin
        offs[i] <= lanes[i].offset;
        cols[i] <= lanes[i].colour;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_keeps_rest: assert property (@(posedge clk) disable iff (rst)
    (fire && rest != '0) |=> (mask == $past(rest)))
    else $error("pixel mask lost or gained bits while a byte was draining");

  a_last_is_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_byte) |-> $onehot(mask))
    else $error("last pixel flagged while more pixels remain");

  a_load_gives_output: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded byte produced no pixel write");
`endif

endmodule

[hdl/mono_bitmap_expand_clip_blit.sv]
// Monochrome color-expansion blit with clipping. Bytes of a 1-bit-per-pixel
// bitmap (leftmost pixel in bit 7, rows padded to whole bytes) come in on the
// input channel; each visible pixel leaves as one frame-buffer write carrying
// its rotated pixel offset (modulo 2^17), its RGB565 color (foreground for a
// 0 bit, background for a 1 bit) and a flag on the last write of the byte.
// Eight lanes judge the eight pixels of a byte in parallel, and a drain stage
// then hands out the hits one per cycle while the output is not stalled, left
// to right. A byte with no visible pixel makes no write and does not wait for
// the drain stage. The next byte is taken while the current one drains, so a
// steady stream runs at one write per cycle while the output is not stalled.
// Registers are to be written through the cfg port only while the block is
// idle; the block itself does not enforce this. The start_of_image flag
// restarts the row and byte counters at this item.
module mono_bitmap_expand_clip_blit #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 272,
  parameter int ROTATION      = 0
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // Bitmap input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pix_byte,
  input  logic        start_of_image,
  // Pixel write channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] pixel_offset,
  output logic [15:0] pixel_color,
  output logic        last_of_byte
);
  import mbecb_pkg::*;

  localparam logic [OFFSET_W-1:0] W17 = OFFSET_W'(SCREEN_WIDTH);
  localparam logic [OFFSET_W-1:0] H17 = OFFSET_W'(SCREEN_HEIGHT);
  localparam logic [1:0]          ROT = 2'(ROTATION);

  // Configuration registers.
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [9:0]         bm_width;
  logic signed [15:0] clip_x;
  logic signed [15:0] clip_y;
  logic [14:0]        clip_w;
  logic [14:0]        clip_h;
  logic [47:0]        colour_pair;

  // Bitmap position counters.
  logic [9:0] row_count;
  logic [6:0] byte_in_row;
  logic [9:0] row_count_next;
  logic [6:0] byte_in_row_next;
  logic [9:0] cur_row;
  logic [6:0] cur_bir;
  logic [7:0] bytes_per_row;
  logic       row_end;

  // Input stage: the accepted byte and where it sits in the bitmap.
  logic       a_valid;
  logic [7:0] a_data;
  logic [9:0] a_row;
  logic [6:0] a_bir;

  logic in_fire;
  logic a_consume;
  logic ser_ready;
  logic any_hit;

  logic signed [17:0]  y;
  logic signed [17:0]  cy;
  logic signed [17:0]  cy_end;
  logic [OFFSET_W-1:0] y17;
  logic [OFFSET_W-1:0] y_term;

  byte_ctx_t ctx;
  lane_res_t lane_res [LANES];

  // The port never holds off a register write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      bm_width    <= 10'd1;
      clip_x      <= '0;
      clip_y      <= '0;
      clip_w      <= '0;
      clip_h      <= '0;
      colour_pair <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X:     origin_x    <= cfg_data[15:0];
        CFG_ORIGIN_Y:     origin_y    <= cfg_data[15:0];
        CFG_BITMAP_WIDTH: bm_width    <= cfg_data[9:0];
        CFG_CLIP_X:       clip_x      <= cfg_data[15:0];
        CFG_CLIP_Y:       clip_y      <= cfg_data[15:0];
        CFG_CLIP_WIDTH:   clip_w      <= cfg_data[14:0];
        CFG_CLIP_HEIGHT:  clip_h      <= cfg_data[14:0];
        CFG_COLOUR_PAIR:  colour_pair <= cfg_data;
      endcase
    end
  end

  // Handshake. The input stage empties when its byte has no visible pixel
  // or when the drain stage can take the lane results.
  assign a_consume = a_valid && (!any_hit || ser_ready);
  assign in_stall  = a_valid && !a_consume;
  assign in_fire   = in_valid && !in_stall;

  // Row and byte counters advance as each byte is accepted. A byte index at
  // or past the row length (after a width change) also ends the row, and a
  // zero width makes every byte a row of its own.
  assign bytes_per_row = 8'((11'(bm_width) + 11'd7) >> 3);
  assign cur_row       = start_of_image ? '0 : row_count;
  assign cur_bir       = start_of_image ? '0 : byte_in_row;
  assign row_end       = ({1'b0, cur_bir} + 8'd1) >= bytes_per_row;

  always_comb begin
    if (row_end) begin
      byte_in_row_next = '0;
      row_count_next   = cur_row + 10'd1;
    end else begin
      byte_in_row_next = cur_bir + 7'd1;
      row_count_next   = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      byte_in_row <= '0;
      a_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        row_count   <= row_count_next;
        byte_in_row <= byte_in_row_next;
        a_valid     <= 1'b1;
      end else if (a_consume) begin
        a_valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_data <= pix_byte;
      a_row  <= cur_row;
      a_bir  <= cur_bir;
    end
  end

  // Row terms shared by all lanes: the vertical clip test at full precision
  // and the row's share of the rotated offset.
  assign y      = $signed({{2{origin_y[15]}}, origin_y}) + $signed({8'b0, a_row});
  assign cy     = $signed({{2{clip_y[15]}}, clip_y});
  assign cy_end = cy + $signed({3'b0, clip_h});
  assign y17    = {y[15], y[15:0]};

  always_comb begin
    unique case (ROT)
      2'd0:    y_term = OFFSET_W'(y17 * W17);
      2'd1:    y_term = W17 - OFFSET_W'(1) - y17;
      2'd2:    y_term = OFFSET_W'((H17 - OFFSET_W'(1) - y17) * W17);
      default: y_term = y17;
    endcase
  end

  assign ctx.col_base = {a_bir, 3'b000};
  assign ctx.bw       = bm_width;
  assign ctx.ox       = $signed({{2{origin_x[15]}}, origin_x});
  assign ctx.cx       = $signed({{2{clip_x[15]}}, clip_x});
  assign ctx.cx_end   = $signed({{2{clip_x[15]}}, clip_x}) + $signed({3'b0, clip_w});
  assign ctx.y_in     = (y >= cy) && (y < cy_end);
  assign ctx.y_term   = y_term;
  assign ctx.fg       = to_rgb565(colour_pair[47:24]);
  assign ctx.bg       = to_rgb565(colour_pair[23:0]);

  // One lane per pixel of the byte; lane 0 is the leftmost pixel (bit 7).
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mbecb_lane #(
      .LANE          (g),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .ROTATION      (ROTATION)
    ) u_lane (
      .ctx     (ctx),
      .pix_bit (a_data[LANES-1-g]),
      .res     (lane_res[g])
    );
  end

  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      any_hit = any_hit | lane_res[i].hit;
    end
  end

  // Drain stage: holds one byte's hits and hands them out one per cycle while the output is not stalled.
  mbecb_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (a_valid && any_hit),
    .lanes        (lane_res),
    .load_ready   (ser_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_offset (pixel_offset),
    .pixel_color  (pixel_color),
    .last_of_byte (last_of_byte)
  );

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && any_hit && !ser_ready))
    else $error("input held off without a byte waiting on the drain stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> a_valid)
    else $error("accepted byte did not reach the input stage");

  a_out_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pixel_offset)
      && $stable(pixel_color) && $stable(last_of_byte)))
    else $error("pixel write changed while the output was stalled");
`endif

endmodule

[verif/tb_mono_bitmap_expand_clip_blit.sv]
module tb_mono_bitmap_expand_clip_blit;
  import mbecb_pkg::*;

  // Screen geometry of the instance. The predictor below uses the same values.
  localparam logic [31:0] SCR_W = 32'd480;
  localparam logic [31:0] SCR_H = 32'd272;
  localparam int          ROT   = 0;

  // Random bytes to send after the directed part, and the watchdog limit in cycles.
  localparam int RANDOM_BYTES = 250;
  localparam int CYCLE_LIMIT  = 400000;

  // Extra cycles given to the block after the last expected write arrives.
  // A byte with no visible pixel makes no write, so it may still be moving
  // through the pipeline at that point.
  localparam int SETTLE_CYCLES = 20;

  // One frame-buffer write, as the block should produce it.
  typedef struct packed {
    logic [16:0] offset;
    logic [15:0] colour;
    logic        last;
  } pixel_write_t;

  // Scoreboard. It keeps a copy of the registers and of the row and byte
  // counters. For each accepted bitmap byte it queues the pixel writes that
  // the byte should cause. Each write seen on the output is checked against
  // the oldest queued write.
  class blit_scoreboard;
    logic signed [15:0] org_x = '0, org_y = '0, clp_x = '0, clp_y = '0;
    logic [9:0]         bmp_w = 10'd1;
    logic [14:0]        clp_w = '0, clp_h = '0;
    logic [47:0]        colours = '0;
    logic [9:0]         row = '0;
    logic [6:0]         col_byte = '0;
    pixel_write_t       expected_writes[$];
    int                 mismatches = 0;
    int                 writes_checked = 0;

    function void set_reg(cfg_reg_t idx, logic [47:0] v);
      case (idx)
        CFG_ORIGIN_X:     org_x = v[15:0];
        CFG_ORIGIN_Y:     org_y = v[15:0];
        CFG_BITMAP_WIDTH: bmp_w = v[9:0];
        CFG_CLIP_X:       clp_x = v[15:0];
        CFG_CLIP_Y:       clp_y = v[15:0];
        CFG_CLIP_WIDTH:   clp_w = v[14:0];
        CFG_CLIP_HEIGHT:  clp_h = v[14:0];
        CFG_COLOUR_PAIR:  colours = v;
        default: ;
      endcase
    endfunction

    // Screen x and y are cut to 16-bit two's complement first. The offset
    // is then formed for the rotation and wraps to 17 bits.
    function logic [16:0] screen_offset(int px, int py);
      logic signed [15:0] xs, ys;
      logic [31:0]        xu, yu, r;
      xs = px[15:0];
      ys = py[15:0];
      xu = xs;
      yu = ys;
      case (ROT)
        0:       r = xu + yu * SCR_W;
        1:       r = xu * SCR_W + (SCR_W - 1 - yu);
        2:       r = (SCR_W - 1 - xu) + (SCR_H - 1 - yu) * SCR_W;
        default: r = (SCR_H - 1 - xu) * SCR_W + yu;
      endcase
      return r[16:0];
    endfunction

    function void note_byte(logic [7:0] pixels, logic sof);
      int           per_row, ox, oy, cx, cy, px, py, col, first;
      logic [15:0]  fg, bg;
      logic         y_hit;
      pixel_write_t w;
      if (sof) begin
        row = '0;
        col_byte = '0;
      end
      per_row = (int'(bmp_w) + 7) >> 3;
      ox = org_x;
      oy = org_y;
      cx = clp_x;
      cy = clp_y;
      // The colors are cut from RGB888 down to RGB565.
      fg = {colours[47:43], colours[39:34], colours[31:27]};
      bg = {colours[23:19], colours[15:10], colours[7:3]};
      py = oy + int'(row);
      y_hit = (py >= cy) && (py < cy + int'(clp_h));
      first = expected_writes.size();
      for (int b = 0; b < 8; b++) begin
        col = int'(col_byte) * 8 + b;
        // Padding bits at the end of a row make no write.
        if (col >= int'(bmp_w)) break;
        px = ox + col;
        if (y_hit && px >= cx && px < cx + int'(clp_w)) begin
          w.offset = screen_offset(px, py);
          w.colour = pixels[7 - b] ? bg : fg;
          w.last   = 1'b0;
          expected_writes.push_back(w);
        end
      end
      if (expected_writes.size() > first)
        expected_writes[expected_writes.size() - 1].last = 1'b1;
      // A byte index at or past the row length ends the row. This also
      // covers a width of zero, and a width that shrank mid-image.
      if (int'(col_byte) + 1 >= per_row) begin
        col_byte = '0;
        row = row + 10'd1;
      end else begin
        col_byte = col_byte + 7'd1;
      end
    endfunction

    function void check_write(logic [16:0] offset, logic [15:0] colour, logic last);
      pixel_write_t w;
      if (expected_writes.size() == 0) begin
        $display("%0t: pixel write with none expected: offset %0d color %h last %b",
                 $time, offset, colour, last);
        mismatches++;
        return;
      end
      w = expected_writes.pop_front();
      writes_checked++;
      if (w.offset !== offset) begin
        $display("%0t: pixel_offset expected %0d, got %0d", $time, w.offset, offset);
        mismatches++;
      end
      if (w.colour !== colour) begin
        $display("%0t: pixel_color expected %h, got %h", $time, w.colour, colour);
        mismatches++;
      end
      if (w.last !== last) begin
        $display("%0t: last_of_byte expected %b, got %b", $time, w.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pix_byte = '0;
  logic        start_of_image = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] pixel_offset;
  logic [15:0] pixel_color;
  logic        last_of_byte;

  blit_scoreboard sb = new();

  // Idle rates in percent. The sender moves through three mixes as the bytes go out.
  int send_idle_pct = 25;
  int recv_idle_pct = 60;
  int bytes_sent = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  mono_bitmap_expand_clip_blit #(
    .SCREEN_WIDTH (int'(SCR_W)),
    .SCREEN_HEIGHT(int'(SCR_H)),
    .ROTATION     (ROT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pix_byte      (pix_byte),
    .start_of_image(start_of_image),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_offset  (pixel_offset),
    .pixel_color   (pixel_color),
    .last_of_byte  (last_of_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver stalls the pixel channel at random. This process is the
  // only one that assigns out_stall, once per edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Every write taken from the block goes to the scoreboard. The outputs
  // are registered, so any byte that leads to a write seen here was noted
  // at an earlier edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_write(pixel_offset, pixel_color, last_of_byte);
  end

  // Watchdog: a run that stops making progress fails here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d writes still expected.",
             cycle_count, sb.pending());
    $display("[mono_bitmap_expand_clip_blit] ERROR");
    $finish;
  end

  // Writes one register and keeps the scoreboard's copy in step.
  // cfg_valid stays high, and send_byte lowers it.
  task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
    reg_writes++;
  endtask

  // Offers one bitmap byte and waits until the block takes it. A run of
  // idle cycles may come first. in_valid is lowered only when a gap really
  // follows, so it never gets two assignments in one time step.
  task automatic send_byte(logic [7:0] pixels, logic sof);
    if (bytes_sent < 95) begin
      send_idle_pct = 25;
      recv_idle_pct = 60;
    end else if (bytes_sent < 190) begin
      send_idle_pct = 60;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pix_byte       <= pixels;
    start_of_image <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(pixels, sof);
    bytes_sent++;
  endtask

  // Waits until every expected write has come out, then gives bytes with
  // no visible pixel time to leave the pipeline. After this the registers
  // may be written.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Picks a screen coordinate. Most fall near the visible screen, and the
  // rest sit at the ends of the 16-bit range or anywhere at all.
  function automatic int pick_coordinate();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return $urandom_range(65535) - 32768;
    if (pick == 1) return 32767 - $urandom_range(16);
    if (pick == 2) return $urandom_range(16) - 32768;
    return $urandom_range(500) - 20;
  endfunction

  initial begin
    int          random_bytes, n_bytes, pick, bw, ox, oy, cx, cy, cw, ch;
    logic        sof;
    logic [47:0] setup [8];
    cfg_reg_t    reg_idx;

    random_bytes = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // After reset the clip window is empty, so bytes only move the counters.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    settle();

    // Width of 12: two bytes per row and four padding bits on the second
    // byte. Three bytes leave the counters one byte into the second row.
    write_reg(CFG_ORIGIN_X, 48'h0);
    write_reg(CFG_ORIGIN_Y, 48'h0);
    write_reg(CFG_BITMAP_WIDTH, 48'd12);
    write_reg(CFG_CLIP_X, 48'h0);
    write_reg(CFG_CLIP_Y, 48'h0);
    write_reg(CFG_CLIP_WIDTH, 48'd480);
    write_reg(CFG_CLIP_HEIGHT, 48'd272);
    write_reg(CFG_COLOUR_PAIR, 48'h000000_FFFFFF);
    send_byte(8'hA5, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    settle();

    // The width shrinks mid-image. The byte index left over from the old
    // width is now past the end of the row, so that byte ends the row and
    // makes no write.
    write_reg(CFG_BITMAP_WIDTH, 48'd3);
    send_byte(8'h81, 1'b0);
    send_byte(8'hE0, 1'b0);
    settle();

    // A width of zero: no writes at all, and every byte ends a row.
    write_reg(CFG_BITMAP_WIDTH, 48'd0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    settle();

    // Coordinates at the ends of the 16-bit range, the widest bitmap, the
    // widest clip window and all-ones colors.
    write_reg(CFG_ORIGIN_X, 48'h8000);
    write_reg(CFG_ORIGIN_Y, 48'h7FFF);
    write_reg(CFG_BITMAP_WIDTH, 48'd1023);
    write_reg(CFG_CLIP_X, 48'h8000);
    write_reg(CFG_CLIP_Y, 48'h0001);
    write_reg(CFG_CLIP_WIDTH, 48'h7FFF);
    write_reg(CFG_CLIP_HEIGHT, 48'h7FFF);
    write_reg(CFG_COLOUR_PAIR, 48'hFFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    settle();

    // Screen x runs past +32767 inside the clip window, so the offset
    // wraps. The top row sits at -32768.
    write_reg(CFG_ORIGIN_X, 48'h7FF8);
    write_reg(CFG_ORIGIN_Y, 48'h8000);
    write_reg(CFG_BITMAP_WIDTH, 48'd16);
    write_reg(CFG_CLIP_X, 48'h7FF8);
    write_reg(CFG_CLIP_Y, 48'h8000);
    write_reg(CFG_CLIP_WIDTH, 48'd100);
    write_reg(CFG_CLIP_HEIGHT, 48'd2);
    write_reg(CFG_COLOUR_PAIR, 48'h123456_ABCDEF);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b0);

    // Random images. Most clip windows sit around the bitmap so that many
    // pixels are written. Some windows are empty or lie anywhere. Each
    // register is left unchanged now and then, and an image does not
    // always begin with start_of_image, so the counters also carry over
    // from one setup to the next.
    while (random_bytes < RANDOM_BYTES) begin
      settle();
      pick = $urandom_range(9);
      if (pick == 0) bw = 0;
      else if (pick == 1) bw = $urandom_range(1023);
      else bw = $urandom_range(1, 40);
      ox = pick_coordinate();
      oy = pick_coordinate();
      pick = $urandom_range(9);
      if (pick == 0) begin
        cx = $urandom_range(65535);
        cy = $urandom_range(65535);
        cw = $urandom_range(32767);
        ch = $urandom_range(32767);
      end else begin
        cx = ox + $urandom_range(8) - 4;
        cy = oy + $urandom_range(3) - 1;
        cw = (pick == 1) ? 0 : $urandom_range(bw + 8);
        ch = (pick == 2) ? 0 : $urandom_range(1, 12);
      end
      setup[CFG_ORIGIN_X]     = {32'd0, ox[15:0]};
      setup[CFG_ORIGIN_Y]     = {32'd0, oy[15:0]};
      setup[CFG_BITMAP_WIDTH] = {38'd0, bw[9:0]};
      setup[CFG_CLIP_X]       = {32'd0, cx[15:0]};
      setup[CFG_CLIP_Y]       = {32'd0, cy[15:0]};
      setup[CFG_CLIP_WIDTH]   = {33'd0, cw[14:0]};
      setup[CFG_CLIP_HEIGHT]  = {33'd0, ch[14:0]};
      setup[CFG_COLOUR_PAIR]  = {16'($urandom_range(65535)), 32'($urandom())};
      reg_idx = reg_idx.first();
      do begin
        if ($urandom_range(4) != 0) write_reg(reg_idx, setup[reg_idx]);
        reg_idx = reg_idx.next();
      end while (reg_idx != reg_idx.first());

      n_bytes = $urandom_range(4, 24);
      for (int k = 0; k < n_bytes; k++) begin
        sof = (k == 0) ? ($urandom_range(4) != 0) : ($urandom_range(29) == 0);
        send_byte(8'($urandom_range(255)), sof);
        random_bytes++;
      end
    end
    settle();

    $display("Sent %0d bitmap bytes and checked %0d pixel writes over %0d register writes,",
             bytes_sent, sb.writes_checked, reg_writes);
    $display("with three mixes of sender and receiver stalls, the last with none.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[mono_bitmap_expand_clip_blit] OK");
    end else begin
      $display("[mono_bitmap_expand_clip_blit] ERROR");
    end
    $finish;
  end

endmodule
